### src/bmccs_pkg.sv
// Package for the bucketed minimum-count column selector.
// Operation codes, field widths, reset constants and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package bmccs_pkg;

	localparam int KIND_W   = 3;
	localparam int COLUMN_W = 9;
	localparam int COUNT_W  = 4;

	localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INCREASE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DECREASE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SELECT   = 3'd4;

	localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 4'd15;

	typedef enum logic [9:0] {
		ST_CLR  = 10'b0000000001, // membership sweep
		ST_IDLE = 10'b0000000010,
		ST_RD   = 10'b0000000100, // column entry read issued
		ST_EVAL = 10'b0000001000, // range check, old bucket read
		ST_UNL  = 10'b0000010000, // unlink from old bucket
		ST_ARD  = 10'b0000100000, // new bucket tail read
		ST_APP  = 10'b0001000000, // append to new bucket
		ST_SCAN = 10'b0010000000, // bucket scan for select
		ST_SEL  = 10'b0100000000, // head of found bucket
		ST_DONE = 10'b1000000000  // result waits for output slot
	} state_t;

endpackage

### src/bucketed_min_count_column_selector_core.sv
// Top level of the bucketed minimum-count column selector.
// Holds the link, count and membership memories and the operation sequencer.
// Depends on bmccs_pkg.
`timescale 1ns / 1ps

// Keeps every member column in a doubly linked list per element count
// (bucket) and answers one result transfer per input transfer. Items are
// processed one at a time by a small sequencer around link memories with
// one read and one write port and registered reads; in_ready is high only
// while it is idle. Steps per operation, from input transfer to result
// ready in the output register: insert/increase/decrease of a member reads
// the column entry, checks it, reads the old bucket, unlinks, reads the new
// tail and appends; insert of a non-member skips the unlink; an increase or
// decrease of a non-member and any rejected count end after the check, an
// unknown kind goes straight to the result. Select scans one bucket per
// cycle from count 1 upward and stops at the first non-empty one or at the
// effective maximum. Clear and reset both run a sweep over the membership
// memory, one column per cycle; no input transfer is taken meanwhile,
// configuration writes still are. The output register frees the input
// side: a new item may be taken while the previous result waits for
// out_ready. max_count is written through the cfg channel (always ready);
// the user must write it only while the block is idle, which the block
// itself does not enforce. Counts above min(max_count, NUM_BUCKETS-1) are rejected with status 1.
module bucketed_min_count_column_selector_core
	import bmccs_pkg::*;
#(
	parameter int NUM_COLUMNS = 512,
	parameter int NUM_BUCKETS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel: max_count
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [COLUMN_W-1:0] column,
	input  logic [COUNT_W-1:0]  amount,
	input  logic [COUNT_W-1:0]  initial_count,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COLUMN_W-1:0] selected_column,
	output logic                found,
	output logic                status
);

	localparam int AW = $clog2(NUM_COLUMNS);
	localparam int BW = $clog2(NUM_BUCKETS);

	state_t state_q;

	logic [COUNT_W-1:0] max_count_q;
	logic [BW-1:0]      eff_max;

	// current item
	logic [KIND_W-1:0]  kind_q;
	logic [AW-1:0]      col_q;
	logic [COUNT_W-1:0] amount_q;
	logic [COUNT_W-1:0] init_q;
	logic [BW-1:0]      bn_q;     // destination bucket
	logic [BW-1:0]      scan_q;   // select scan position
	logic [AW-1:0]      clr_q;    // sweep position
	logic               clr_op_q; // sweep answers a clear item

	// pending result and output register
	logic [COLUMN_W-1:0] res_sel_q;
	logic                res_found_q;
	logic                res_status_q;
	logic                out_valid_q;
	logic [COLUMN_W-1:0] out_sel_q;
	logic                out_found_q;
	logic                out_status_q;

	logic [NUM_BUCKETS-1:0] ne_q; // bucket non-empty flags

	// memories and their registered read data
	logic [AW-1:0]      nxt_mem [NUM_COLUMNS];
	logic [AW-1:0]      prv_mem [NUM_COLUMNS];
	logic [COUNT_W-1:0] cnt_mem [NUM_COLUMNS];
	logic               mbr_mem [NUM_COLUMNS];
	logic [AW-1:0]      head_mem [NUM_BUCKETS];
	logic [AW-1:0]      tail_mem [NUM_BUCKETS];

	logic [AW-1:0]      nx_rd_q;
	logic [AW-1:0]      pv_rd_q;
	logic [COUNT_W-1:0] cnt_rd_q;
	logic               mbr_rd_q;
	logic [AW-1:0]      head_rd_q;
	logic [AW-1:0]      tail_rd_q;

	// write ports
	logic               nxt_we, prv_we, cnt_we, mbr_we, head_we, tail_we;
	logic [AW-1:0]      nxt_wa, prv_wa, mbr_wa;
	logic [AW-1:0]      nxt_wd, prv_wd, head_wd;
	logic               mbr_wd;
	logic [BW-1:0]      head_wa, tail_wa;
	logic [AW-1:0]      tail_wd;
	logic [BW-1:0]      head_ra, tail_ra;

	// unlink / append decode
	logic [BW-1:0] bo;
	logic          is_head, is_tail, only_one;
	logic          bn_ne;

	// range check
	logic [COUNT_W:0]   inc_sum;
	logic [COUNT_W-1:0] dec_diff;
	logic               col_ok;

	logic in_xfer, out_xfer, out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;

	assign out_valid       = out_valid_q;
	assign selected_column = out_sel_q;
	assign found           = out_found_q;
	assign status          = out_status_q;
	assign out_xfer        = out_valid_q && out_ready;
	assign out_load        = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		if (int'(max_count_q) > NUM_BUCKETS - 1) begin
			eff_max = BW'(NUM_BUCKETS - 1);
		end else begin
			eff_max = BW'(max_count_q);
		end
	end

	assign col_ok   = int'(column) < NUM_COLUMNS;
	assign inc_sum  = {1'b0, cnt_rd_q} + {1'b0, amount_q};
	assign dec_diff = cnt_rd_q - amount_q;

	// old bucket of the column under work; count memory is stable until append
	assign bo       = BW'(cnt_rd_q);
	assign is_head  = (head_rd_q == col_q);
	assign is_tail  = (tail_rd_q == col_q);
	assign only_one = is_head && is_tail;
	assign bn_ne    = ne_q[bn_q];

	// bucket memory read addresses
	assign head_ra = (state_q == ST_SCAN) ? scan_q : bo;
	assign tail_ra = (state_q == ST_ARD) ? bn_q : bo;

	always_comb begin
		nxt_we  = 1'b0; nxt_wa = pv_rd_q;  nxt_wd = nx_rd_q;
		prv_we  = 1'b0; prv_wa = nx_rd_q;  prv_wd = pv_rd_q;
		head_we = 1'b0; head_wa = bo;      head_wd = nx_rd_q;
		tail_we = 1'b0; tail_wa = bo;      tail_wd = pv_rd_q;
		cnt_we  = 1'b0;
		mbr_we  = 1'b0; mbr_wa = col_q;    mbr_wd = 1'b1;
		case (state_q)
			ST_CLR: begin
				mbr_we = 1'b1;
				mbr_wa = clr_q;
				mbr_wd = 1'b0;
			end
			ST_UNL: begin
				if (!only_one) begin
					// predecessor (or head) skips the column
					head_we = is_head;
					nxt_we  = !is_head;
					// successor (or tail) points back past it
					tail_we = is_tail;
					prv_we  = !is_tail;
				end
			end
			ST_APP: begin
				tail_we = 1'b1;
				tail_wa = bn_q;
				tail_wd = col_q;
				cnt_we  = 1'b1;
				mbr_we  = 1'b1;
				if (bn_ne) begin
					nxt_we = 1'b1;
					nxt_wa = tail_rd_q;
					nxt_wd = col_q;
					prv_we = 1'b1;
					prv_wa = col_q;
					prv_wd = tail_rd_q;
				end else begin
					head_we = 1'b1;
					head_wa = bn_q;
					head_wd = col_q;
				end
			end
			default: begin
			end
		endcase
	end

	// column memories, read continuously at the column under work
	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (cnt_we) cnt_mem[col_q] <= COUNT_W'(bn_q);
		if (mbr_we) mbr_mem[mbr_wa] <= mbr_wd;
		nx_rd_q  <= nxt_mem[col_q];
		pv_rd_q  <= prv_mem[col_q];
		cnt_rd_q <= cnt_mem[col_q];
		mbr_rd_q <= mbr_mem[col_q];
	end

	// bucket memories
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		if (tail_we) tail_mem[tail_wa] <= tail_wd;
		head_rd_q <= head_mem[head_ra];
		tail_rd_q <= tail_mem[tail_ra];
	end

	// item payload and result holding registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q       <= kind;
			col_q        <= AW'(column);
			amount_q     <= amount;
			init_q       <= initial_count;
			res_sel_q    <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= 1'b0;
			scan_q       <= BW'(1);
		end
		case (state_q)
			ST_EVAL: begin
				case (kind_q)
					KIND_INSERT: begin
						bn_q <= BW'(init_q);
						if (init_q > eff_max) res_status_q <= 1'b1;
					end
					KIND_INCREASE: begin
						bn_q <= BW'(inc_sum);
						if (mbr_rd_q && inc_sum > (COUNT_W+1)'(eff_max)) begin
							res_status_q <= 1'b1;
						end
					end
					KIND_DECREASE: begin
						bn_q <= BW'(dec_diff);
						if (mbr_rd_q && (amount_q > cnt_rd_q || dec_diff > eff_max)) begin
							res_status_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				if (!ne_q[scan_q]) scan_q <= scan_q + BW'(1);
			end
			ST_SEL: begin
				res_sel_q   <= COLUMN_W'(head_rd_q);
				res_found_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_sel_q    <= res_sel_q;
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			clr_op_q    <= 1'b0;
			ne_q        <= '0;
			out_valid_q <= 1'b0;
			max_count_q <= MAX_COUNT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) max_count_q <= cfg_data;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					if (clr_q == AW'(NUM_COLUMNS - 1)) begin
						clr_q   <= '0;
						state_q <= clr_op_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						case (kind)
							KIND_CLEAR: begin
								ne_q     <= '0;
								clr_op_q <= 1'b1;
								state_q  <= ST_CLR;
							end
							KIND_INSERT, KIND_INCREASE, KIND_DECREASE: begin
								state_q <= col_ok ? ST_RD : ST_DONE;
							end
							KIND_SELECT: begin
								state_q <= (eff_max == '0) ? ST_DONE : ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					case (kind_q)
						KIND_INSERT: begin
							if (init_q > eff_max) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= mbr_rd_q ? ST_UNL : ST_ARD;
							end
						end
						KIND_INCREASE: begin
							if (!mbr_rd_q || inc_sum > (COUNT_W+1)'(eff_max)) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_UNL;
							end
						end
						KIND_DECREASE: begin
							if (!mbr_rd_q || amount_q > cnt_rd_q || dec_diff > eff_max) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_UNL;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_UNL: begin
					if (only_one) ne_q[bo] <= 1'b0;
					state_q <= ST_ARD;
				end
				ST_ARD: begin
					state_q <= ST_APP;
				end
				ST_APP: begin
					ne_q[bn_q] <= 1'b1;
					state_q    <= ST_DONE;
				end
				ST_SCAN: begin
					if (ne_q[scan_q]) begin
						state_q <= ST_SEL;
					end else if (scan_q == eff_max) begin
						state_q <= ST_DONE;
					end
				end
				ST_SEL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						clr_op_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sim/column_buckets_pkg.sv
// Predictor and result checker for the bucketed minimum-count column selector bench.
// Mirrors the bucket lists, counts and memberships and keeps the answers still due.
// Depends on bmccs_pkg.
`timescale 1ns / 1ps

package column_buckets_pkg;

	import bmccs_pkg::*;

	localparam int NUM_COLS = 512;
	localparam int NUM_BKTS = 16;

	// kinds above select are decoded as no-ops
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_SELECT + 3'd1;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [COLUMN_W-1:0] column;
		logic [COUNT_W-1:0]  amount;
		logic [COUNT_W-1:0]  initial_count;
	} op_t;

	typedef struct packed {
		logic [COLUMN_W-1:0] selected_column;
		logic                found;
		logic                status;
	} answer_t;

	class column_buckets;
		bit [COUNT_W-1:0]  limit;
		bit [COLUMN_W-1:0] head [NUM_BKTS];
		bit [COLUMN_W-1:0] tail [NUM_BKTS];
		bit                filled [NUM_BKTS];
		bit [COLUMN_W-1:0] next_col [NUM_COLS];
		bit [COLUMN_W-1:0] prev_col [NUM_COLS];
		bit [COUNT_W-1:0]  count [NUM_COLS];
		bit                listed [NUM_COLS];
		answer_t           answers_due [$];
		int                errors;

		function new();
			limit = MAX_COUNT_RESET;
			errors = 0;
		endfunction

		function int pending();
			return answers_due.size();
		endfunction

		function void detach(bit [COLUMN_W-1:0] c);
			bit [COUNT_W-1:0]  b;
			bit [COLUMN_W-1:0] nx;
			bit [COLUMN_W-1:0] pv;
			b = count[c];
			nx = next_col[c];
			pv = prev_col[c];
			if (head[b] == c && tail[b] == c) begin
				filled[b] = 1'b0;
			end else begin
				if (head[b] == c)
					head[b] = nx;
				else
					next_col[pv] = nx;
				if (tail[b] == c)
					tail[b] = pv;
				else
					prev_col[nx] = pv;
			end
			listed[c] = 1'b0;
		endfunction

		function void attach(bit [COLUMN_W-1:0] c, bit [COUNT_W-1:0] b);
			if (filled[b]) begin
				next_col[tail[b]] = c;
				prev_col[c] = tail[b];
				tail[b] = c;
			end else begin
				head[b] = c;
				tail[b] = c;
				filled[b] = 1'b1;
			end
			count[c] = b;
			listed[c] = 1'b1;
		endfunction

		function answer_t next_answer(op_t op);
			answer_t          r;
			bit [COUNT_W:0]   nc;
			r = '0;
			case (op.kind)
				KIND_CLEAR: begin
					foreach (filled[i]) filled[i] = 1'b0;
					foreach (listed[i]) listed[i] = 1'b0;
				end
				KIND_SELECT: begin
					// bucket 0 is never a candidate
					for (int b = 1; b <= limit && !r.found; b++) begin
						if (filled[b]) begin
							r.selected_column = head[b];
							r.found = 1'b1;
						end
					end
				end
				KIND_INSERT: begin
					if (op.initial_count > limit) begin
						r.status = 1'b1;
					end else begin
						if (listed[op.column])
							detach(op.column);
						attach(op.column, op.initial_count);
					end
				end
				KIND_INCREASE, KIND_DECREASE: begin
					if (listed[op.column]) begin
						// one extra bit: a negative result wraps above any limit
						if (op.kind == KIND_INCREASE)
							nc = {1'b0, count[op.column]} + {1'b0, op.amount};
						else
							nc = {1'b0, count[op.column]} - {1'b0, op.amount};
						if (nc > {1'b0, limit}) begin
							r.status = 1'b1;
						end else begin
							detach(op.column);
							attach(op.column, nc[COUNT_W-1:0]);
						end
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		// Notes an accepted item and queues the answer it is due.
		function void take_item(op_t op);
			answers_due.push_back(next_answer(op));
		endfunction

		function void compare_field(string name, logic [COLUMN_W-1:0] want,
				logic [COLUMN_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void match_answer(logic [COLUMN_W-1:0] sel, logic fnd, logic st);
			answer_t want;
			if (answers_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got column %0d found %0d status %0d",
					$time, sel, fnd, st);
				return;
			end
			want = answers_due.pop_front();
			compare_field("selected_column", want.selected_column, sel);
			compare_field("found", COLUMN_W'(want.found), COLUMN_W'(fnd));
			compare_field("status", COLUMN_W'(want.status), COLUMN_W'(st));
		endfunction
	endclass

endpackage

### sim/bucketed_min_count_column_selector_core_test.sv
// Self-checking bench for bucketed_min_count_column_selector_core.
// Directed and random operations against a predictor with random stalls on both sides.
// Depends on bmccs_pkg and column_buckets_pkg.
`timescale 1ns / 1ps

module bucketed_min_count_column_selector_core_test;

	import bmccs_pkg::*;
	import column_buckets_pkg::*;

	// Run budget. Worst item: longest sender gap, a full select scan and the
	// longest receiver stall; plus the sweeps for reset and every clear and
	// two receiver hold-offs of HOLD_CYCLES. Several times over that.
	localparam int CYCLE_LIMIT     = 500_000;
	localparam int HOLD_CYCLES     = 300;
	localparam int ITEMS_PER_PHASE = 237;
	localparam int TAIL_CYCLES     = 20;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [KIND_W-1:0]   kind;
	logic [COLUMN_W-1:0] column;
	logic [COUNT_W-1:0]  amount;
	logic [COUNT_W-1:0]  initial_count;
	logic                out_valid;
	logic                out_ready;
	logic [COLUMN_W-1:0] selected_column;
	logic                found;
	logic                status;

	column_buckets board;
	bit            hold_results = 1'b0;  // asks the result sink for a long hold-off
	int unsigned   cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bucketed_min_count_column_selector_core #(
		.NUM_COLUMNS(NUM_COLS),
		.NUM_BUCKETS(NUM_BKTS)
	) dut (
		.clk,
		.arst_n,
		.cfg_valid,
		.cfg_ready,
		.cfg_data,
		.in_valid,
		.in_ready,
		.kind,
		.column,
		.amount,
		.initial_count,
		.out_valid,
		.out_ready,
		.selected_column,
		.found,
		.status
	);

	// Hard stop in case a transfer never happens.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bucketed_min_count_column_selector_core_test: done, errors");
			$finish;
		end
	end

	// Result monitor: every result transfer is checked against the oldest
	// answer still due. Sampled at the edge, so all values are pre-edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.match_answer(selected_column, found, status);
	end

	// Result sink. Mostly ready in runs, short and occasional long stalls,
	// and a long hold-off on request so the output register fills and the
	// block has to stall its input side.
	initial begin : result_sink
		int pick;
		int len;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					out_ready <= 1'b1;
					len = $urandom_range(1, 20);
				end else if (pick < 92) begin
					out_ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					len = $urandom_range(8, 30);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// All driver tasks start and end right after a rising edge.

	// max_count write; cfg channel is separate from the item path.
	task automatic write_max_count(input logic [COUNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.limit = value;
		cfg_valid <= 1'b0;
	endtask

	// Offers one item and holds it until the input transfer. in_valid is
	// left high so a back-to-back item needs no second assignment.
	task automatic send_op(input op_t o);
		in_valid      <= 1'b1;
		kind          <= o.kind;
		column        <= o.column;
		amount        <= o.amount;
		initial_count <= o.initial_count;
		do @(posedge clk); while (!in_ready);
		board.take_item(o);
	endtask

	// Random gap after a transfer: often none, mostly short, a few long.
	task automatic sender_gap(input bit eager);
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (eager || pick < 55)
			len = 0;
		else if (pick < 90)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(8, 40);
		if (len > 0) begin
			in_valid <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// Sender pause until every answer due has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic issue(input logic [KIND_W-1:0] k, input logic [COLUMN_W-1:0] c,
			input logic [COUNT_W-1:0] a, input logic [COUNT_W-1:0] i);
		op_t o;
		o.kind          = k;
		o.column        = c;
		o.amount        = a;
		o.initial_count = i;
		send_op(o);
		sender_gap(1'b0);
	endtask

	// Random phase. Columns come mostly from a small pool so the bucket
	// lists grow long and moves hit heads, tails and middles; now and then
	// any column, any amount and out-of-range counts.
	task automatic run_random(input int n_items, input int pool_size, input bit eager);
		bit [COLUMN_W-1:0] pool [32];
		op_t               o;
		int                done_items;
		int                pick;
		foreach (pool[i]) pool[i] = COLUMN_W'($urandom_range(0, NUM_COLS - 1));
		done_items = 0;
		while (done_items < n_items) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				o.column = COLUMN_W'($urandom_range(0, NUM_COLS - 1));
			else
				o.column = pool[$urandom_range(0, pool_size - 1)];
			if ($urandom_range(0, 3) == 0)
				o.amount = COUNT_W'($urandom_range(0, 15));
			else
				o.amount = COUNT_W'($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0)
				o.initial_count = COUNT_W'($urandom_range(0, 15));
			else
				o.initial_count = COUNT_W'($urandom_range(0, board.limit));
			if (pick < 3)
				o.kind = KIND_CLEAR;
			else if (pick < 33)
				o.kind = KIND_INSERT;
			else if (pick < 53)
				o.kind = KIND_INCREASE;
			else if (pick < 73)
				o.kind = KIND_DECREASE;
			else if (pick < 95)
				o.kind = KIND_SELECT;
			else
				o.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
			send_op(o);
			done_items++;
			if (!eager && $urandom_range(0, 199) == 0)
				wait_drained();
			else
				sender_gap(eager);
		end
	endtask

	initial begin : stimulus
		logic [COUNT_W-1:0] phase_max [6];
		board = new();
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		kind          <= KIND_CLEAR;
		column        <= '0;
		amount        <= '0;
		initial_count <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Written during the reset sweep, which still takes cfg transfers.
		write_max_count(MAX_COUNT_RESET);

		// Directed part at the full range.
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);   // nothing anywhere
		issue(KIND_INSERT,   9'd0,   4'd0,  4'd0);
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);   // bucket 0 is skipped
		issue(KIND_INSERT,   9'd511, 4'd0,  4'd15);
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);   // top bucket
		issue(KIND_INSERT,   9'd170, 4'd0,  4'd1);
		issue(KIND_INSERT,   9'd341, 4'd0,  4'd1);
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);
		issue(KIND_INCREASE, 9'd170, 4'd0,  4'd0);   // zero amount: to own tail
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);
		issue(KIND_INCREASE, 9'd341, 4'd15, 4'd0);   // above max, rejected
		issue(KIND_DECREASE, 9'd0,   4'd1,  4'd0);   // below zero, rejected
		issue(KIND_DECREASE, 9'd511, 4'd15, 4'd0);   // down to bucket 0
		issue(KIND_INCREASE, 9'd0,   4'd12, 4'd0);
		issue(KIND_INSERT,   9'd341, 4'd0,  4'd12);  // re-insert of a member
		issue(KIND_INCREASE, 9'd100, 4'd1,  4'd0);   // not a member, dropped
		issue(KIND_SPARE_LO, 9'd511, 4'd15, 4'd15);
		issue(KIND_SPARE_HI, 9'd511, 4'd15, 4'd15);
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);
		issue(KIND_DECREASE, 9'd170, 4'd1,  4'd0);
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);   // column 0 found
		issue(KIND_CLEAR,    9'd0,   4'd0,  4'd0);
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);
		issue(KIND_DECREASE, 9'd0,   4'd0,  4'd0);   // membership was dropped
		issue(KIND_INSERT,   9'd85,  4'd0,  4'd12);

		// Lowered maximum: column 85 stays in bucket 12 but is not scanned.
		wait_drained();
		write_max_count(4'd3);
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);
		issue(KIND_INSERT,   9'd2,   4'd0,  4'd4);   // above the new max
		issue(KIND_INCREASE, 9'd85,  4'd0,  4'd0);   // still above, rejected
		issue(KIND_DECREASE, 9'd85,  4'd10, 4'd0);   // back into range
		issue(KIND_SELECT,   9'd0,   4'd0,  4'd0);

		// Random phases, each at its own max_count. Phases 1 and 4 run an
		// eager sender against a receiver hold-off.
		phase_max[0] = 4'd1;
		phase_max[1] = 4'd15;
		phase_max[2] = 4'd7;
		phase_max[3] = 4'd2;
		phase_max[4] = COUNT_W'($urandom_range(1, 15));
		phase_max[5] = 4'd12;
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			write_max_count(phase_max[p]);
			if (p == 1 || p == 4)
				hold_results = 1'b1;
			run_random(ITEMS_PER_PHASE, $urandom_range(4, 32), p == 1 || p == 4);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("bucketed_min_count_column_selector_core_test: done, clean");
		else
			$display("bucketed_min_count_column_selector_core_test: done, errors");
		$finish;
	end

endmodule
